FILE: sv/fric_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fric_pkg
// Types and constants shared by the FIFO-replacement identifier cache.
// ----------------------------------------------------------------------------
package fric_pkg;

    localparam int ID_W         = 32;
    localparam int CNT_W        = 5;
    localparam int AGE_W        = 4;
    localparam int RESULT_LIMIT = 16;

    localparam logic FUNC_ACCESS  = 1'b0;
    localparam logic FUNC_READOUT = 1'b1;

    typedef logic [ID_W-1:0]  t_ident;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [AGE_W-1:0] t_age;

    typedef struct packed {
        logic   func;
        t_ident ident;
    } t_req;

    typedef struct packed {
        logic   hit;
        logic   evicted_valid;
        t_ident evicted_ident;
        logic   entry_valid;
        t_ident entry_ident;
        t_cnt   occupancy;
        logic   last;
    } t_rsp;

    // input register contents as seen by the sequencer
    typedef struct packed {
        logic valid;
        t_req req;
    } t_head;

    // sequencer -> store
    typedef struct packed {
        logic   is_access;
        logic   upd;
        t_ident ident;
        t_age   rd_age;
    } t_store_cmd;

    // store -> sequencer
    typedef struct packed {
        logic   hit;
        logic   ev_valid;
        t_ident ev_ident;
        t_cnt   occ_next;
        t_cnt   count;
        t_cnt   cap;
        t_ident rd_ident;
    } t_store_stat;

endpackage

FILE: sv/fric_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fric_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface fric_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/fifo_replacement_id_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_replacement_id_cache
// Fully associative identifier cache with first-in first-out replacement.
// ----------------------------------------------------------------------------
// Channels: i_req takes {func, ident}; func access looks ident up and
// inserts it on a miss, evicting the oldest entry when full; func readout
// lists the stored identifiers newest first. o_rsp returns one result per
// access, one per stored entry on readout (a single invalid result when
// empty), with last set on the final result of each request.
// Path: a request passes through the input register, then the result
// register, before its result is valid on o_rsp.
// Throughput: while o_rsp is ready, one access per cycle, set by the parallel
// compare against all slots and ring insert; a readout holds the input
// register until its last entry is read, reading one entry per cycle.
// Reset: the store is empty and capacity is min(16, CAPACITY). A write on
// i_cfg_we sets capacity (0 acts as 1, larger values saturate) and empties
// the store; write only while no request is in flight.
// Stall: while o_rsp is not ready the result register holds and the input
// register fills once, after which i_req.ready drops.
// ----------------------------------------------------------------------------
module fifo_replacement_id_cache #(
    parameter int CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fric_pkg::CNT_W-1:0] i_cfg_wdata,
    fric_stream_if.sink                i_req,
    fric_stream_if.source              o_rsp
);
    import fric_pkg::*;

    localparam int SLOTS = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

    t_head       w_head;
    t_store_cmd  w_cmd;
    t_store_stat w_stat;
    t_rsp        w_rsp;
    logic        w_can_load;
    logic        w_fire;
    logic        w_is_acc;
    logic        w_empty;
    logic        w_last_entry;
    logic        w_take;
    t_age        r_age;
    t_age        n_age;

    fric_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_take),
        .o_head  (w_head)
    );

    fric_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    fric_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_data     (w_rsp),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

    assign w_fire       = w_head.valid && w_can_load;
    assign w_is_acc     = (w_head.req.func == FUNC_ACCESS);
    assign w_empty      = (w_stat.count == '0);
    assign w_last_entry = (CNT_W'(r_age) + CNT_W'(1) == w_stat.count);
    assign w_take       = w_fire && (w_is_acc || w_empty || w_last_entry);

    assign w_cmd.is_access = w_is_acc;
    assign w_cmd.upd       = w_fire && w_is_acc;
    assign w_cmd.ident     = w_head.req.ident;
    assign w_cmd.rd_age    = r_age;

    always_comb begin
        w_rsp = '0;
        case (w_head.req.func)
            FUNC_ACCESS: begin
                w_rsp.hit           = w_stat.hit;
                w_rsp.evicted_valid = w_stat.ev_valid;
                w_rsp.evicted_ident = w_stat.ev_ident;
                w_rsp.occupancy     = w_stat.occ_next;
                w_rsp.last          = 1'b1;
            end
            FUNC_READOUT: begin
                w_rsp.entry_valid = !w_empty;
                w_rsp.entry_ident = w_empty ? '0 : w_stat.rd_ident;
                w_rsp.occupancy   = w_stat.count;
                w_rsp.last        = w_empty || w_last_entry;
            end
            default: begin
                w_rsp = '0;
            end
        endcase
    end

    // readout walks one age per transfer; back to zero when the request retires
    always_comb begin
        n_age = r_age;
        if (w_take) begin
            n_age = '0;
        end else if (w_fire) begin
            n_age = r_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else begin
            r_age <= n_age;
        end
    end

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.count <= w_stat.cap))
        else $error("fill count exceeds capacity");

    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_is_acc && w_stat.ev_valid) |=>
        (o_rsp.payload.occupancy == w_stat.cap))
        else $error("eviction while store not full");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.payload.hit && o_rsp.payload.evicted_valid))
        else $error("hit and eviction in one result");

    a_age_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_age != '0) |-> (w_head.valid && w_head.req.func == FUNC_READOUT
                           && CNT_W'(r_age) < w_stat.count))
        else $error("readout position outside a readout");

endmodule

FILE: sv/fric_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fric_in_reg
// Input register: holds one request until the sequencer retires it.
// ----------------------------------------------------------------------------
module fric_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fric_stream_if.sink       i_req,
    input  logic              i_take,
    output fric_pkg::t_head   o_head
);
    import fric_pkg::*;

    logic r_valid;
    t_req r_req;
    logic w_load;

    assign i_req.ready = !r_valid || i_take;
    assign w_load      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_req <= i_req.payload;
        end
    end

    assign o_head.valid = r_valid;
    assign o_head.req   = r_req;

endmodule

FILE: sv/fric_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fric_store
// Identifier ring with parallel lookup, newest pointer, fill count and
// effective capacity register.
// ----------------------------------------------------------------------------
module fric_store #(
    parameter int SLOTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fric_pkg::CNT_W-1:0] i_cfg_wdata,
    input  fric_pkg::t_store_cmd      i_cmd,
    output fric_pkg::t_store_stat     o_stat
);
    import fric_pkg::*;

    localparam int   SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam t_cnt SLOTS_C = CNT_W'(SLOTS);

    t_ident          r_slot [SLOTS];
    logic [SW-1:0]   r_newest;
    logic [SW-1:0]   n_newest;
    t_cnt            r_count;
    t_cnt            n_count;
    t_cnt            r_cap;
    t_cnt            n_cap;

    t_cnt            w_newest;
    t_cnt            w_ins;
    t_cnt            w_rd;
    t_cnt            w_age;
    t_cnt            w_addr;
    logic            w_full;
    logic [SLOTS-1:0] w_match;
    logic            w_hit;
    t_ident          w_word;

    assign w_newest = CNT_W'(r_newest);
    assign w_full   = (r_count == r_cap);
    assign w_ins    = (w_newest + CNT_W'(1) == r_cap) ? '0 : w_newest + CNT_W'(1);
    assign w_age    = CNT_W'(i_cmd.rd_age);
    // slot of the entry rd_age places behind the newest, wrapping at cap
    assign w_rd     = w_newest - w_age + ((w_newest < w_age) ? r_cap : '0);

    // a slot is live if it lies inside the ring and its age is below the count
    always_comb begin
        t_cnt s_idx;
        t_cnt s_age;
        for (int s = 0; s < SLOTS; s++) begin
            s_idx      = CNT_W'(s);
            s_age      = w_newest - s_idx + ((w_newest < s_idx) ? r_cap : '0);
            w_match[s] = (s_idx < r_cap) && (s_age < r_count)
                         && (r_slot[s] == i_cmd.ident);
        end
    end

    assign w_hit  = |w_match;
    assign w_addr = i_cmd.is_access ? w_ins : w_rd;
    assign w_word = r_slot[w_addr[SW-1:0]];

    always_comb begin
        n_newest = r_newest;
        n_count  = r_count;
        n_cap    = r_cap;
        if (i_cfg_we) begin
            n_newest = '0;
            n_count  = '0;
            if (i_cfg_wdata == '0) begin
                n_cap = CNT_W'(1);
            end else if (i_cfg_wdata > SLOTS_C) begin
                n_cap = SLOTS_C;
            end else begin
                n_cap = i_cfg_wdata;
            end
        end else if (i_cmd.upd && !w_hit) begin
            n_newest = w_ins[SW-1:0];
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_count  <= '0;
            r_cap    <= SLOTS_C;
        end else begin
            r_newest <= n_newest;
            r_count  <= n_count;
            r_cap    <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && !w_hit && !i_cfg_we) begin
            r_slot[w_ins[SW-1:0]] <= i_cmd.ident;
        end
    end

    assign o_stat.hit      = w_hit;
    assign o_stat.ev_valid = !w_hit && w_full;
    assign o_stat.ev_ident = (!w_hit && w_full) ? w_word : '0;
    assign o_stat.occ_next = (w_hit || w_full) ? r_count : r_count + CNT_W'(1);
    assign o_stat.count    = r_count;
    assign o_stat.cap      = r_cap;
    assign o_stat.rd_ident = w_word;

endmodule

FILE: sv/fric_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fric_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module fric_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  fric_pkg::t_rsp  i_data,
    output logic            o_can_load,
    fric_stream_if.source   o_rsp
);
    import fric_pkg::*;

    logic r_valid;
    t_rsp r_data;

    assign o_can_load = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.payload = r_data;

endmodule

FILE: verif/tb_fifo_replacement_id_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_replacement_id_cache
// Self-checking bench for the FIFO-replacement identifier cache. A driver
// fed from a backlog of requests and capacity writes offers the requests on
// i_req. A monitor predicts the result stream of every accepted request and
// compares each o_rsp transfer field by field against the oldest
// prediction. Capacity settings and idle patterns change from phase to phase.
// ----------------------------------------------------------------------------
module tb_fifo_replacement_id_cache;
    import fric_pkg::*;

    localparam int DUT_CAPACITY   = 16;
    localparam int MAX_SLOTS      = (DUT_CAPACITY < RESULT_LIMIT) ? DUT_CAPACITY : RESULT_LIMIT;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic {
        STIM_REQ,
        STIM_CAPACITY
    } t_stim_kind;

    typedef struct {
        t_stim_kind kind;
        t_req       req;
        t_cnt       capacity;
        int         send_idle;
        int         recv_stall;
        bit         long_hold;
    } t_stim;

    logic clk;
    logic rst_n;
    logic cfg_we;
    t_cnt cfg_wdata;

    fric_stream_if #(.T(t_req)) req_if ();
    fric_stream_if #(.T(t_rsp)) rsp_if ();

    fifo_replacement_id_cache #(
        .CAPACITY (DUT_CAPACITY)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // backlog of stimulus and results still owed by the block
    t_stim req_backlog[$];
    t_rsp  due_rsp[$];

    // shadow copy of the cache
    t_ident      model_slot [MAX_SLOTS];
    int unsigned model_newest = 0;
    int unsigned model_count  = 0;
    t_cnt        model_cap    = t_cnt'(16);

    int fails         = 0;
    int settle_cycles = 0;
    int quiet_cycles  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold      = 1'b0;
    logic req_took;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void predict_cache(input t_req rq);
        int unsigned cap;
        int unsigned pos;
        int unsigned age;
        bit          found;
        t_rsp        r;
        cap = (model_cap == 0) ? 1 : ((model_cap > MAX_SLOTS) ? MAX_SLOTS : model_cap);
        if (rq.func == FUNC_ACCESS) begin
            found = 1'b0;
            for (age = 0; age < model_count; age++) begin
                if (model_slot[(model_newest + cap - age) % cap] == rq.ident) found = 1'b1;
            end
            r      = '0;
            r.hit  = found;
            r.last = 1'b1;
            if (!found) begin
                pos = (model_newest + 1) % cap;
                if (model_count >= cap) begin
                    r.evicted_valid = 1'b1;
                    r.evicted_ident = model_slot[pos];
                end else begin
                    model_count++;
                end
                model_slot[pos] = rq.ident;
                model_newest    = pos;
            end
            r.occupancy = t_cnt'(model_count);
            due_rsp = {due_rsp, r};
        end else if (model_count == 0) begin
            r      = '0;
            r.last = 1'b1;
            due_rsp = {due_rsp, r};
        end else begin
            for (age = 0; age < model_count; age++) begin
                r             = '0;
                r.entry_valid = 1'b1;
                r.entry_ident = model_slot[(model_newest + cap - age) % cap];
                r.occupancy   = t_cnt'(model_count);
                r.last        = (age + 1 == model_count);
                due_rsp = {due_rsp, r};
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    task automatic add_access(input t_ident id);
        t_stim s;
        s           = '{kind: STIM_REQ, default: 0};
        s.kind      = STIM_REQ;
        s.req.func  = FUNC_ACCESS;
        s.req.ident = id;
        req_backlog = {req_backlog, s};
    endtask

    task automatic add_readout();
        t_stim s;
        s           = '{kind: STIM_REQ, default: 0};
        s.kind      = STIM_REQ;
        s.req.func  = FUNC_READOUT;
        s.req.ident = $urandom;
        req_backlog = {req_backlog, s};
    endtask

    task automatic add_capacity(input t_cnt value, input int send_idle, input int recv_stall,
                                input bit hold);
        t_stim s;
        s            = '{kind: STIM_CAPACITY, default: 0};
        s.kind       = STIM_CAPACITY;
        s.capacity   = value;
        s.send_idle  = send_idle;
        s.recv_stall = recv_stall;
        s.long_hold  = hold;
        req_backlog  = {req_backlog, s};
    endtask

    // mostly identifiers from a small pool so hits and evictions both occur
    task automatic add_random(input int count, input int pool);
        t_ident base;
        int     pick;
        base = $urandom;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 10) add_readout();
            else if (pick < 20) add_access($urandom);
            else add_access(base ^ t_ident'($urandom_range(pool)));
        end
    endtask

    // ------------------------------------------------------------------
    // request driver and capacity writes (falling edge)
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive
        logic  nxt_valid;
        t_req  nxt_req;
        logic  nxt_we;
        t_cnt  nxt_wdata;
        t_stim head;
        nxt_valid = req_if.valid;
        nxt_req   = req_if.payload;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata;
        if (req_if.valid || due_rsp.size() != 0) settle_cycles = 0;
        else if (settle_cycles < SETTLE_CYCLES) settle_cycles++;
        if (rst_n && !(req_if.valid && !req_took)) begin
            nxt_valid = 1'b0;
            if (req_backlog.size() != 0) begin
                head = req_backlog[0];
                if (head.kind == STIM_CAPACITY) begin
                    // only once the block has gone quiet
                    if (settle_cycles >= SETTLE_CYCLES) begin
                        nxt_we         = 1'b1;
                        nxt_wdata      = head.capacity;
                        model_cap      = head.capacity;
                        model_count    = 0;
                        model_newest   = 0;
                        send_idle_pct  <= head.send_idle;
                        recv_stall_pct <= head.recv_stall;
                        long_hold      <= head.long_hold;
                        req_backlog.delete(0);
                    end
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    nxt_valid = 1'b1;
                    nxt_req   = head.req;
                    req_backlog.delete(0);
                end
            end
        end
        req_if.valid   <= nxt_valid;
        req_if.payload <= nxt_req;
        cfg_we         <= nxt_we;
        cfg_wdata      <= nxt_wdata;
    end

    // ------------------------------------------------------------------
    // result receiver (falling edge)
    // ------------------------------------------------------------------
    always @(negedge clk) begin : receive
        int hold_cnt;
        bit hold_done;
        if (!rst_n) begin
            hold_cnt  = 0;
            hold_done = 1'b0;
            rsp_if.ready <= 1'b0;
        end else if (long_hold && !hold_done) begin
            // long back-pressure: the input side fills and stalls
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor (rising edge)
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_rsp want;
        t_rsp got;
        if (!rst_n) begin
            req_took <= 1'b0;
        end else begin
            req_took <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) predict_cache(req_if.payload);
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.payload;
                if (due_rsp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fails++;
                end else begin
                    want = due_rsp[0];
                    due_rsp.delete(0);
                    check_field("hit", want.hit, got.hit);
                    check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
                    check_field("evicted_ident", want.evicted_ident, got.evicted_ident);
                    check_field("entry_valid", want.entry_valid, got.entry_valid);
                    check_field("entry_ident", want.entry_ident, got.entry_ident);
                    check_field("occupancy", want.occupancy, got.occupancy);
                    check_field("last", want.last, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no transfer on either channel for too long
    // ------------------------------------------------------------------
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_took       = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;

        // directed: reset capacity, empty readout, extreme identifiers, hit
        add_readout();
        add_access(32'h0000_0000);
        add_access(32'hFFFF_FFFF);
        add_access(32'h0000_0000);
        add_access(32'hA5A5_A5A5);
        add_access(32'h5A5A_5A5A);
        add_readout();
        // zero capacity acts as one; the write also empties the store
        add_capacity(t_cnt'(0), 0, 0, 1'b0);
        add_access(32'h1234_5678);
        add_access(32'h1234_5678);
        add_access(32'h8765_4321);
        add_readout();
        add_capacity(t_cnt'(2), 0, 0, 1'b0);
        add_readout();
        add_access(32'h0000_0001);
        add_access(32'h0000_0002);
        add_access(32'h0000_0003);
        add_access(32'h0000_0002);
        add_readout();

        // random phases; out-of-range capacities saturate
        add_capacity(t_cnt'(31), 0, 0, 1'b1);
        add_random(45, 20);
        add_capacity(t_cnt'(16), 53, 0, 1'b0);
        add_random(35, 20);
        add_capacity(t_cnt'(5), 0, 53, 1'b0);
        add_random(35, 8);
        add_capacity(t_cnt'(1), 36, 36, 1'b0);
        add_random(25, 3);
        add_capacity(t_cnt'(17), 36, 36, 1'b0);
        add_random(30, 20);

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_if.valid || due_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_rsp.size() != 0) begin
            $display("%0t: %0d results expected but never seen", $time, due_rsp.size());
            fails++;
        end
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
